/* sv/rar_pkg.sv */
// Shared widths, operation codes and the queue entry type for the rational reduce unit.
package rar_pkg;

  // Width of each input field
  localparam int IN_W = 16;
  // Cross products and the raw numerator after the add or subtract
  localparam int PROD_W = 2 * IN_W;
  localparam int NUM_W = PROD_W + 1;
  // Magnitudes handled by the reduction datapath
  localparam int MAG_W = NUM_W;
  localparam int K_W = $clog2(MAG_W + 1);
  localparam int CNT_W = $clog2(MAG_W);

  // Result field widths
  localparam int NUM_OUT_W = 33;
  localparam int DEN_OUT_W = 31;

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Operation codes
  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_DIV = 2'd3;

  // One classified item waiting for reduction
  typedef struct packed {
    logic signed [NUM_W-1:0]  num;
    logic signed [PROD_W-1:0] den;
    logic                     den_zero;
    logic                     num_zero;
  } rar_entry_t;

endpackage

/* sv/rar_ifs.sv */
// Valid/ready channel interfaces for the input and result words.
interface rar_in_if import rar_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [1:0]             cmd;
  logic signed [IN_W-1:0] a_num;
  logic signed [IN_W-1:0] a_den;
  logic signed [IN_W-1:0] b_num;
  logic signed [IN_W-1:0] b_den;

  modport source (output valid, cmd, a_num, a_den, b_num, b_den, input ready);
  modport sink (input valid, cmd, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rar_out_if import rar_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [NUM_OUT_W-1:0] res_num;
  logic [DEN_OUT_W-1:0]        res_den;
  logic                        zero_den_error;

  modport source (output valid, res_num, res_den, zero_den_error, input ready);
  modport sink (input valid, res_num, res_den, zero_den_error, output ready);
endinterface

/* sv/rational_arith_reduce_unit.sv */
// Top level: rational add/sub/mul/div with reduction to lowest terms.
//
//   Channel   Dir  Handshake      Word
//   in_ch     in   valid/ready    cmd, a_num, a_den, b_num, b_den
//   out_ch    out  valid/ready    res_num, res_den, zero_den_error
//
// The front end takes a word each cycle its product stage can drain and queues it
// two deep. The back end reduces one word at a time: a load from the queue, a binary
// GCD of one step a cycle, a bit-serial division by the GCD and a load into the
// result register; the GCD loop and divider set the rate. Zero-denominator and
// zero-numerator words skip the GCD and division. Synchronous active-low reset
// empties the queue and result register. A stalled result register holds the back
// end; the full queue then holds the front end.
module rational_arith_reduce_unit import rar_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  rar_in_if.sink    in_ch,
  rar_out_if.source out_ch
);

  logic       push_valid, push_ready;
  rar_entry_t push_data;
  logic       pop_valid, pop_ready;
  rar_entry_t pop_data;

  rar_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  rar_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  rar_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule

/* sv/rar_front.sv */
// Front end: accepts input words, forms the cross products and classifies the raw fraction.
module rar_front import rar_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  rar_in_if.sink     in_ch,
  output logic       push_valid,
  input  logic       push_ready,
  output rar_entry_t push_data
);

  logic                     valid_a_r;
  logic signed [PROD_W-1:0] p0_r;
  logic signed [PROD_W-1:0] p1_r;
  logic signed [PROD_W-1:0] pd_r;
  logic                     sub_r;

  logic signed [PROD_W-1:0] an_x, ad_x, bn_x, bd_x;
  logic signed [PROD_W-1:0] m0_b, md_b;
  logic signed [PROD_W-1:0] p0_nxt, p1_nxt, pd_nxt;
  logic                     use_p1;
  logic                     take;
  logic signed [NUM_W-1:0]  num_sum;

  // Accept while the product stage is empty or drains this cycle
  assign in_ch.ready = !valid_a_r || push_ready;
  assign take = in_ch.valid && in_ch.ready;

  // Select multiplier operands by operation
  assign an_x = PROD_W'(in_ch.a_num);
  assign ad_x = PROD_W'(in_ch.a_den);
  assign bn_x = PROD_W'(in_ch.b_num);
  assign bd_x = PROD_W'(in_ch.b_den);

  always_comb begin
    m0_b   = bd_x;
    md_b   = bd_x;
    use_p1 = 1'b0;
    unique case (in_ch.cmd)
      CMD_ADD: begin
        use_p1 = 1'b1;
      end
      CMD_SUB: begin
        use_p1 = 1'b1;
      end
      CMD_MUL: begin
        m0_b = bn_x;
      end
      CMD_DIV: begin
        md_b = bn_x;
      end
      default: begin
        use_p1 = 1'b0;
      end
    endcase
  end

  assign p0_nxt = an_x * m0_b;
  assign p1_nxt = use_p1 ? (ad_x * bn_x) : '0;
  assign pd_nxt = ad_x * md_b;

  // Hold the product stage valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
    end else if (take) begin
      valid_a_r <= 1'b1;
    end else if (push_ready) begin
      valid_a_r <= 1'b0;
    end
  end

  // Capture products of the accepted word
  always_ff @(posedge clk) begin
    if (take) begin
      p0_r  <= p0_nxt;
      p1_r  <= p1_nxt;
      pd_r  <= pd_nxt;
      sub_r <= (in_ch.cmd == CMD_SUB);
    end
  end

  // Combine products and classify for the back end
  assign num_sum = sub_r ? (NUM_W'(p0_r) - NUM_W'(p1_r)) : (NUM_W'(p0_r) + NUM_W'(p1_r));

  assign push_valid         = valid_a_r;
  assign push_data.num      = num_sum;
  assign push_data.den      = pd_r;
  assign push_data.den_zero = (pd_r == '0);
  assign push_data.num_zero = (num_sum == '0);

endmodule

/* sv/rar_queue.sv */
// Short queue that decouples the front end from the reduction back end.
module rar_queue import rar_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  rar_entry_t push_data,
  output logic       pop_valid,
  input  logic       pop_ready,
  output rar_entry_t pop_data
);

  rar_entry_t        slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push, do_pop;

  assign push_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* sv/rar_back.sv */
// Back end: binary GCD, bit-serial division by the GCD and the result register.
module rar_back import rar_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  rar_entry_t pop_data,
  rar_out_if.source  out_ch
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_GCD  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]                  state_r, state_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        neg_r, neg_nxt;
  logic                        err_r, err_nxt;
  logic [MAG_W-1:0]            u_r, u_nxt;
  logic [MAG_W-1:0]            v_r, v_nxt;
  logic [K_W-1:0]              k_r, k_nxt;
  logic [MAG_W-1:0]            g_r, g_nxt;
  logic [MAG_W-1:0]            qn_r, qn_nxt;
  logic [MAG_W-1:0]            qd_r, qd_nxt;
  logic [MAG_W-1:0]            rn_r, rn_nxt;
  logic [MAG_W-1:0]            rd_r, rd_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic signed [NUM_OUT_W-1:0] res_num_r;
  logic [DEN_OUT_W-1:0]        res_den_r;
  logic                        res_err_r;

  logic                        out_free, out_load;
  logic signed [NUM_W-1:0]     den_ext, num_abs, den_abs;
  logic [MAG_W:0]              rn_sh, rd_sh, g_ext;
  logic                        rn_ge, rd_ge;
  logic [MAG_W-1:0]            u_minus_v, v_minus_u;
  logic signed [MAG_W:0]       signed_q;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign out_load  = (state_r == ST_OUT) && out_free;
  assign pop_ready = (state_r == ST_IDLE);

  // Magnitudes of the popped fraction
  assign den_ext = NUM_W'(pop_data.den);
  assign num_abs = pop_data.num[NUM_W-1] ? -pop_data.num : pop_data.num;
  assign den_abs = den_ext[NUM_W-1] ? -den_ext : den_ext;

  // One restoring division step on both quotients
  assign g_ext     = {1'b0, g_r};
  assign rn_sh     = {rn_r, qn_r[MAG_W-1]};
  assign rd_sh     = {rd_r, qd_r[MAG_W-1]};
  assign rn_ge     = (rn_sh >= g_ext);
  assign rd_ge     = (rd_sh >= g_ext);
  assign u_minus_v = u_r - v_r;
  assign v_minus_u = v_r - u_r;

  // Sign goes on the numerator
  assign signed_q = neg_r ? -$signed({1'b0, qn_r}) : $signed({1'b0, qn_r});

  always_comb begin
    state_nxt = state_r;
    neg_nxt   = neg_r;
    err_nxt   = err_r;
    u_nxt     = u_r;
    v_nxt     = v_r;
    k_nxt     = k_r;
    g_nxt     = g_r;
    qn_nxt    = qn_r;
    qd_nxt    = qd_r;
    rn_nxt    = rn_r;
    rd_nxt    = rd_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (pop_valid) begin
          neg_nxt = 1'b0;
          err_nxt = 1'b0;
          priority if (pop_data.den_zero) begin
            // Zero denominator: flag the error, zero fraction
            err_nxt   = 1'b1;
            qn_nxt    = '0;
            qd_nxt    = '0;
            state_nxt = ST_OUT;
          end else if (pop_data.num_zero) begin
            // Zero numerator reduces to 0/1
            qn_nxt    = '0;
            qd_nxt    = MAG_W'(1);
            state_nxt = ST_OUT;
          end else begin
            neg_nxt   = pop_data.num[NUM_W-1] ^ pop_data.den[PROD_W-1];
            qn_nxt    = MAG_W'(num_abs);
            qd_nxt    = MAG_W'(den_abs);
            u_nxt     = MAG_W'(num_abs);
            v_nxt     = MAG_W'(den_abs);
            k_nxt     = '0;
            state_nxt = ST_GCD;
          end
        end
      end
      ST_GCD: begin
        if (u_r == '0 || v_r == '0) begin
          // GCD found: restore the common power of two
          g_nxt     = (u_r | v_r) << k_r;
          rn_nxt    = '0;
          rd_nxt    = '0;
          cnt_nxt   = CNT_W'(MAG_W - 1);
          state_nxt = ST_DIV;
        end else begin
          unique case ({u_r[0], v_r[0]})
            2'b00: begin
              u_nxt = u_r >> 1;
              v_nxt = v_r >> 1;
              k_nxt = k_r + 1'b1;
            end
            2'b01: begin
              u_nxt = u_r >> 1;
            end
            2'b10: begin
              v_nxt = v_r >> 1;
            end
            default: begin
              // Both odd: the difference is even, halve it at once
              if (u_r >= v_r) begin
                u_nxt = u_minus_v >> 1;
              end else begin
                v_nxt = v_minus_u >> 1;
              end
            end
          endcase
        end
      end
      ST_DIV: begin
        qn_nxt = {qn_r[MAG_W-2:0], rn_ge};
        qd_nxt = {qd_r[MAG_W-2:0], rd_ge};
        rn_nxt = rn_ge ? MAG_W'(rn_sh - g_ext) : MAG_W'(rn_sh);
        rd_nxt = rd_ge ? MAG_W'(rd_sh - g_ext) : MAG_W'(rd_sh);
        if (cnt_r == '0) begin
          state_nxt = ST_OUT;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output valid: set on load, drop when taken
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    err_r <= err_nxt;
    u_r   <= u_nxt;
    v_r   <= v_nxt;
    k_r   <= k_nxt;
    g_r   <= g_nxt;
    qn_r  <= qn_nxt;
    qd_r  <= qd_nxt;
    rn_r  <= rn_nxt;
    rd_r  <= rd_nxt;
    cnt_r <= cnt_nxt;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      res_num_r <= NUM_OUT_W'(signed_q);
      res_den_r <= DEN_OUT_W'(qd_r);
      res_err_r <= err_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.res_num        = res_num_r;
  assign out_ch.res_den        = res_den_r;
  assign out_ch.zero_den_error = res_err_r;

endmodule
